/* sv/lob_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_pkg: shared types and codes for the limit order book matcher
// Result kinds, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package lob_pkg;

  localparam int unsigned BookDepthDefault = 32;

  localparam int unsigned IdW    = 32;
  localparam int unsigned PriceW = 20;
  localparam int unsigned QtyW   = 24;
  localparam int unsigned KindW  = 3;

  localparam logic [KindW-1:0] KIND_TRADE     = 3'd0;
  localparam logic [KindW-1:0] KIND_RESTED    = 3'd1;
  localparam logic [KindW-1:0] KIND_FILLED    = 3'd2;
  localparam logic [KindW-1:0] KIND_CANCELLED = 3'd3;
  localparam logic [KindW-1:0] KIND_NOTFOUND  = 3'd4;
  localparam logic [KindW-1:0] KIND_REJECTED  = 3'd5;

  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_CANCEL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_TRADE,
    ST_CANCEL,
    ST_STATUS,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the request beat
    logic fill;        // execute one fill at the head of the opposite book
    logic do_cancel;   // remove the first matching entry of each book
    logic do_status;   // resolve the final status item (fill, rest or reject)
    logic out_load;    // result register takes the pending item
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_cancel;
    logic can_fill;    // remainder nonzero and opposite head crosses
    logic last_item;   // pending item is the final one
    logic any_hit;     // some resting entry still carries the request id
  } status_t;

endpackage

/* sv/lob_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_datapath: bid and ask cell chains plus the request registers
// Each book is a shift chain of sorted cells; slot 0 holds the best order.
// ----------------------------------------------------------------------------
module lob_datapath #(
  parameter int unsigned BOOK_DEPTH = lob_pkg::BookDepthDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lob_pkg::cmd_t               cmd,
  output lob_pkg::status_t            sts,
  input  logic                        in_mode,
  input  logic [lob_pkg::IdW-1:0]     in_id,
  input  logic                        in_side,
  input  logic [lob_pkg::PriceW-1:0]  in_price,
  input  logic [lob_pkg::QtyW-1:0]    in_qty,
  output logic [lob_pkg::KindW-1:0]   o_kind,
  output logic [lob_pkg::IdW-1:0]     o_buy_id,
  output logic [lob_pkg::IdW-1:0]     o_sell_id,
  output logic [lob_pkg::QtyW-1:0]    o_trade_qty,
  output logic [lob_pkg::PriceW-1:0]  o_trade_price,
  output logic [lob_pkg::QtyW-1:0]    o_left_qty,
  output logic                        o_last
);

  localparam int unsigned D = BOOK_DEPTH;

  // request registers
  logic                       mode;
  logic [lob_pkg::IdW-1:0]    oid;
  logic                       side;
  logic [lob_pkg::PriceW-1:0] price;
  logic [lob_pkg::QtyW-1:0]   rem;
  logic                       found;

  // books: index 0 bids, 1 asks
  logic [D-1:0]               valid  [2];
  logic [lob_pkg::IdW-1:0]    ids    [2][D];
  logic [lob_pkg::PriceW-1:0] prices [2][D];
  logic [lob_pkg::QtyW-1:0]   qtys   [2][D];

  // pending result item
  logic [lob_pkg::KindW-1:0]  p_kind;
  logic [lob_pkg::IdW-1:0]    p_buy, p_sell;
  logic [lob_pkg::QtyW-1:0]   p_tq, p_lq;
  logic [lob_pkg::PriceW-1:0] p_tp;
  logic                       p_last;

  logic                       opp;
  logic                       head_cross;
  logic [lob_pkg::QtyW-1:0]   head_q, fill_q;
  logic                       head_gone;

  // crossing test on the opposite book head
  always_comb begin
    opp    = ~side;
    head_q = qtys[opp][0];
    if (side == 1'b0) begin
      head_cross = valid[1][0] && (prices[1][0] <= price);
    end else begin
      head_cross = valid[0][0] && (prices[0][0] >= price);
    end
    fill_q    = (rem < head_q) ? rem : head_q;
    head_gone = (fill_q == head_q);
  end

  assign sts.is_cancel = (mode == lob_pkg::MODE_CANCEL);
  assign sts.can_fill  = (rem != '0) && head_cross;
  assign sts.last_item = p_last;

  // per-cell cancel match and insert position
  logic [D-1:0] hit [2];
  logic [D-1:0] keep_before;   // own-book cells that stay ahead of the new order
  logic         own;
  logic         own_full;
  logic         any_hit;

  always_comb begin
    own = side;
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < D; i++) begin
        hit[b][i] = valid[b][i] && (ids[b][i] == oid);
      end
    end
    for (int i = 0; i < D; i++) begin
      if (own == 1'b0) begin
        keep_before[i] = valid[0][i] && (prices[0][i] >= price);
      end else begin
        keep_before[i] = valid[1][i] && (prices[1][i] <= price);
      end
    end
    own_full = valid[own][D-1];
    any_hit  = (|hit[0]) || (|hit[1]);
  end

  assign sts.any_hit = any_hit;

  // cancel compaction: the first hit of each book leaves, cells above it move down
  logic [D-1:0] past_hit [2];
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      past_hit[b][0] = hit[b][0];
      for (int i = 1; i < D; i++) begin
        past_hit[b][i] = past_hit[b][i-1] | hit[b][i];
      end
    end
  end

  // request capture and remainder
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode  <= in_mode;
      oid   <= in_id;
      side  <= in_side;
      price <= in_price;
      rem   <= in_qty;
      found <= 1'b0;
    end else if (cmd.fill) begin
      rem <= rem - fill_q;
    end else if (cmd.do_cancel) begin
      found <= found | any_hit;
    end
  end

  // book update
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= '0;
      valid[1] <= '0;
    end else if (cmd.fill) begin
      if (head_gone) begin
        for (int i = 0; i < D - 1; i++) begin
          ids[opp][i]    <= ids[opp][i+1];
          prices[opp][i] <= prices[opp][i+1];
          qtys[opp][i]   <= qtys[opp][i+1];
        end
        valid[opp] <= valid[opp] >> 1;
      end else begin
        qtys[opp][0] <= head_q - fill_q;
      end
    end else if (cmd.do_cancel) begin
      for (int b = 0; b < 2; b++) begin
        if (|hit[b]) begin
          for (int i = 0; i < D - 1; i++) begin
            if (past_hit[b][i]) begin
              ids[b][i]    <= ids[b][i+1];
              prices[b][i] <= prices[b][i+1];
              qtys[b][i]   <= qtys[b][i+1];
            end
          end
          valid[b] <= valid[b] >> 1;
        end
      end
    end else if (cmd.do_status && rem != '0 && !own_full) begin
      for (int i = 0; i < D; i++) begin
        if (!keep_before[i]) begin
          if (i > 0 && !keep_before[i-1]) begin
            ids[own][i]    <= ids[own][i-1];
            prices[own][i] <= prices[own][i-1];
            qtys[own][i]   <= qtys[own][i-1];
          end else begin
            ids[own][i]    <= oid;
            prices[own][i] <= price;
            qtys[own][i]   <= rem;
          end
        end
      end
      valid[own] <= {valid[own][D-2:0], 1'b1};
    end
  end

  // pending item selection
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      p_kind <= lob_pkg::KIND_TRADE;
      p_buy  <= (side == 1'b0) ? oid : ids[0][0];
      p_sell <= (side == 1'b0) ? ids[1][0] : oid;
      p_tq   <= fill_q;
      p_tp   <= prices[opp][0];
      p_lq   <= '0;
      p_last <= 1'b0;
    end else if (cmd.do_cancel) begin
      p_kind <= (found || any_hit) ? lob_pkg::KIND_CANCELLED : lob_pkg::KIND_NOTFOUND;
      p_buy  <= oid;
      p_sell <= '0;
      p_tq   <= '0;
      p_tp   <= '0;
      p_lq   <= '0;
      p_last <= 1'b1;
    end else if (cmd.do_status) begin
      p_buy  <= oid;
      p_sell <= '0;
      p_tq   <= '0;
      p_tp   <= '0;
      p_lq   <= rem;
      p_last <= 1'b1;
      priority if (rem == '0) begin
        p_kind <= lob_pkg::KIND_FILLED;
      end else if (own_full) begin
        p_kind <= lob_pkg::KIND_REJECTED;
      end else begin
        p_kind <= lob_pkg::KIND_RESTED;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_kind        <= p_kind;
      o_buy_id      <= p_buy;
      o_sell_id     <= p_sell;
      o_trade_qty   <= p_tq;
      o_trade_price <= p_tp;
      o_left_qty    <= p_lq;
      o_last        <= p_last;
    end
  end

endmodule

/* sv/lob_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_ctrl: request sequencer
// Steps through fills, cancel and the status item, one result beat at a time.
// ----------------------------------------------------------------------------
module lob_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lob_pkg::status_t  sts,
  output lob_pkg::cmd_t     cmd
);

  lob_pkg::state_t state, state_next;
  logic            ovalid, ovalid_next;
  logic            slot_free;

  assign slot_free = !ovalid || out_ready;
  assign out_valid = ovalid;

  // next state
  always_comb begin
    state_next  = state;
    ovalid_next = ovalid && !out_ready;
    unique case (state)
      lob_pkg::ST_IDLE: begin
        if (in_valid) state_next = lob_pkg::ST_DECIDE;
      end
      lob_pkg::ST_DECIDE: begin
        priority if (sts.is_cancel) begin
          state_next = lob_pkg::ST_CANCEL;
        end else if (sts.can_fill) begin
          state_next = lob_pkg::ST_TRADE;
        end else begin
          state_next = lob_pkg::ST_STATUS;
        end
      end
      // one matching entry per book leaves each cycle until none is left
      lob_pkg::ST_CANCEL: begin
        state_next = sts.any_hit ? lob_pkg::ST_CANCEL : lob_pkg::ST_OUT;
      end
      lob_pkg::ST_TRADE,
      lob_pkg::ST_STATUS: state_next = lob_pkg::ST_OUT;
      lob_pkg::ST_OUT: begin
        if (slot_free) begin
          ovalid_next = 1'b1;
          state_next  = sts.last_item ? lob_pkg::ST_IDLE : lob_pkg::ST_DECIDE;
        end
      end
      default: state_next = lob_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state)
      lob_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lob_pkg::ST_TRADE:  cmd.fill      = 1'b1;
      lob_pkg::ST_CANCEL: cmd.do_cancel = 1'b1;
      lob_pkg::ST_STATUS: cmd.do_status = 1'b1;
      lob_pkg::ST_OUT:    cmd.out_load  = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= lob_pkg::ST_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

endmodule

/* sv/limit_order_book_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_matcher: price-time priority order book
// Adds cross the opposite book and rest the remainder; cancels remove by id.
// ----------------------------------------------------------------------------
// Requests arrive one beat at a time with the mode (add or cancel) on s_tuser;
// each request gives one or more result beats with the kind on m_tuser and the
// final beat marked by m_tlast. An add steps through decide, fill and result
// for each fill of the opposite book head, as the sequencer handles one fill
// at a time, then decide, status and result for the status beat. A cancel
// steps through decide, cancel and result, staying in cancel while a resting
// entry matches, as each book drops one matching entry a cycle. The next
// request is accepted once the final beat has moved into the output register,
// which holds it while the consumer stalls. No clearing pass after reset.
module limit_order_book_matcher #(
  parameter int unsigned BOOK_DEPTH = lob_pkg::BookDepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // order_id, side, price, qty, pad
  input  logic         s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // buy_id, sell_id, trade_qty, trade_price,
                                  // left_qty, pad
  output logic [2:0]   m_tuser,   // kind
  output logic         m_tlast    // last
);

  lob_pkg::cmd_t    cmd;
  lob_pkg::status_t sts;

  logic [lob_pkg::IdW-1:0]    buy_id, sell_id;
  logic [lob_pkg::QtyW-1:0]   trade_qty, left_qty;
  logic [lob_pkg::PriceW-1:0] trade_price;

  lob_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lob_datapath #(.BOOK_DEPTH(BOOK_DEPTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (s_tuser),
    .in_id         (s_tdata[31:0]),
    .in_side       (s_tdata[32]),
    .in_price      (s_tdata[52:33]),
    .in_qty        (s_tdata[76:53]),
    .o_kind        (m_tuser),
    .o_buy_id      (buy_id),
    .o_sell_id     (sell_id),
    .o_trade_qty   (trade_qty),
    .o_trade_price (trade_price),
    .o_left_qty    (left_qty),
    .o_last        (m_tlast)
  );

  // pack result beat
  assign m_tdata = {4'b0000, left_qty, trade_price, trade_qty, sell_id, buy_id};

endmodule

/* tb/sv/lob_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_checker: order book scoreboard
// Watches request and result beats, keeps its own bid and ask books, works out
// the trades and status each request causes and compares them field by field.
// ----------------------------------------------------------------------------
module lob_checker #(
  parameter int unsigned DEPTH = lob_pkg::BookDepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [79:0]  s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [135:0] m_tdata,
  input  logic [2:0]   m_tuser,
  input  logic         m_tlast,
  output int           errors,
  output int           pending,
  output int           n_trades,
  output int           n_status
);

  typedef struct packed {
    logic [lob_pkg::KindW-1:0]  kind;
    logic [lob_pkg::IdW-1:0]    buy_id;
    logic [lob_pkg::IdW-1:0]    sell_id;
    logic [lob_pkg::QtyW-1:0]   trade_qty;
    logic [lob_pkg::PriceW-1:0] trade_price;
    logic [lob_pkg::QtyW-1:0]   left_qty;
    logic                       last;
  } fill_rec_t;

  typedef struct {
    int                         n;
    logic [lob_pkg::IdW-1:0]    id [DEPTH];
    logic [lob_pkg::PriceW-1:0] px [DEPTH];
    logic [lob_pkg::QtyW-1:0]   qt [DEPTH];
  } book_t;

  book_t bids, asks;
  fill_rec_t fills_due [$];

  function automatic fill_rec_t mk(logic [lob_pkg::KindW-1:0] k, logic [lob_pkg::IdW-1:0] b,
      logic [lob_pkg::IdW-1:0] s, logic [lob_pkg::QtyW-1:0] tq,
      logic [lob_pkg::PriceW-1:0] tp, logic [lob_pkg::QtyW-1:0] lq, logic l);
    fill_rec_t r;
    r.kind = k; r.buy_id = b; r.sell_id = s; r.trade_qty = tq;
    r.trade_price = tp; r.left_qty = lq; r.last = l;
    return r;
  endfunction

  function automatic void drop_at(ref book_t bk, input int i);
    for (int j = i; j + 1 < bk.n; j++) begin
      bk.id[j] = bk.id[j+1]; bk.px[j] = bk.px[j+1]; bk.qt[j] = bk.qt[j+1];
    end
    bk.n--;
  endfunction

  function automatic bit place(ref book_t bk, input bit desc,
      input logic [lob_pkg::IdW-1:0] oid, input logic [lob_pkg::PriceW-1:0] p,
      input logic [lob_pkg::QtyW-1:0] q);
    int pos;
    pos = 0;
    if (bk.n >= DEPTH) return 1'b0;
    while (pos < bk.n && (desc ? bk.px[pos] >= p : bk.px[pos] <= p)) pos++;
    for (int j = bk.n; j > pos; j--) begin
      bk.id[j] = bk.id[j-1]; bk.px[j] = bk.px[j-1]; bk.qt[j] = bk.qt[j-1];
    end
    bk.id[pos] = oid; bk.px[pos] = p; bk.qt[pos] = q;
    bk.n++;
    return 1'b1;
  endfunction

  function automatic int purge(ref book_t bk, input logic [lob_pkg::IdW-1:0] oid);
    int i, cnt;
    i = 0; cnt = 0;
    while (i < bk.n) begin
      if (bk.id[i] == oid) begin
        drop_at(bk, i); cnt++;
      end else i++;
    end
    return cnt;
  endfunction

  // work out the beats one request causes
  function automatic void match_request(logic mode, logic [79:0] d);
    logic                       sell;
    logic [lob_pkg::IdW-1:0]    oid;
    logic [lob_pkg::PriceW-1:0] px;
    logic [lob_pkg::QtyW-1:0]   rem, t;
    int                         hits;
    bit                         ok;
    oid = d[31:0]; sell = d[32]; px = d[52:33]; rem = d[76:53];
    if (mode == lob_pkg::MODE_CANCEL) begin
      hits = purge(bids, oid) + purge(asks, oid);
      fills_due.push_back(mk(hits != 0 ? lob_pkg::KIND_CANCELLED : lob_pkg::KIND_NOTFOUND,
                             oid, '0, '0, '0, '0, 1'b1));
      return;
    end
    if (!sell) begin
      while (rem != 0 && asks.n > 0 && asks.px[0] <= px) begin
        t = rem < asks.qt[0] ? rem : asks.qt[0];
        fills_due.push_back(mk(lob_pkg::KIND_TRADE, oid, asks.id[0], t, asks.px[0],
                               '0, 1'b0));
        rem -= t; asks.qt[0] -= t;
        if (asks.qt[0] == 0) drop_at(asks, 0);
      end
    end else begin
      while (rem != 0 && bids.n > 0 && bids.px[0] >= px) begin
        t = rem < bids.qt[0] ? rem : bids.qt[0];
        fills_due.push_back(mk(lob_pkg::KIND_TRADE, bids.id[0], oid, t, bids.px[0],
                               '0, 1'b0));
        rem -= t; bids.qt[0] -= t;
        if (bids.qt[0] == 0) drop_at(bids, 0);
      end
    end
    if (rem == 0) fills_due.push_back(mk(lob_pkg::KIND_FILLED, oid, '0, '0, '0, '0, 1'b1));
    else begin
      ok = sell ? place(asks, 1'b0, oid, px, rem) : place(bids, 1'b1, oid, px, rem);
      fills_due.push_back(mk(ok ? lob_pkg::KIND_RESTED : lob_pkg::KIND_REJECTED,
                             oid, '0, '0, '0, rem, 1'b1));
    end
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    fill_rec_t got, want;
    if (rst) begin
      bids.n = 0; asks.n = 0;
      fills_due.delete();
      errors = 0; n_trades = 0; n_status = 0; pending = 0;
    end else begin
      if (s_tvalid && s_tready) match_request(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got = mk(m_tuser, m_tdata[31:0], m_tdata[63:32], m_tdata[87:64],
                 m_tdata[107:88], m_tdata[131:108], m_tlast);
        if (fills_due.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, got);
          errors++;
        end else begin
          want = fills_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
          end
          if (want.kind == lob_pkg::KIND_TRADE) n_trades++;
          else n_status++;
        end
      end
      pending = fills_due.size();
    end
  end

endmodule

/* tb/sv/tb_limit_order_book_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher: order book regression
// Directed corner requests, then random add/cancel traffic around a narrow
// price band so orders cross, rest, fill books and get cancelled, with bursty
// requests and a stalling consumer.
// ----------------------------------------------------------------------------
module tb_limit_order_book_matcher;

  localparam int Depth = lob_pkg::BookDepthDefault;
  localparam int Limit = 400000;

  logic         clk, rst;
  logic         s_tvalid, s_tready, s_tuser;
  logic [79:0]  s_tdata;
  logic         m_tvalid, m_tready, m_tlast;
  logic [135:0] m_tdata;
  logic [2:0]   m_tuser;
  int           errors, pending, n_trades, n_status;
  int           cycles;
  logic [31:0]  used_ids [$];
  int           burst_left;

  limit_order_book_matcher #(.BOOK_DEPTH(Depth)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  lob_checker #(.DEPTH(Depth)) chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .errors(errors), .pending(pending), .n_trades(n_trades), .n_status(n_status)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > Limit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // consumer stall pattern: runs of ready and runs of stall
  initial begin
    int run;
    m_tready = 0;
    forever begin
      run = $urandom_range(1, 12);
      repeat (run) begin
        @(negedge clk);
        m_tready = 1;
      end
      if ($urandom_range(0, 3) != 0) begin
        run = $urandom_range(1, 6);
        repeat (run) begin
          @(negedge clk);
          m_tready = 0;
        end
      end
    end
  end

  // one request beat, with bursty gaps before it
  task automatic send_req(logic mode, logic [31:0] oid, logic side,
      logic [19:0] px, logic [23:0] q);
    if (burst_left == 0) begin
      s_tvalid = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    s_tdata = {3'b000, q, px, side, oid};
    s_tuser = mode;
    s_tvalid = 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (burst_left == 0) s_tvalid = 0;
    if (mode == lob_pkg::MODE_ADD) used_ids.push_back(oid);
  endtask

  task automatic add_order(logic [31:0] oid, logic side, logic [19:0] px, logic [23:0] q);
    send_req(lob_pkg::MODE_ADD, oid, side, px, q);
  endtask

  initial begin
    logic [31:0] next_id, cid;
    logic [19:0] px;
    logic [23:0] q;
    int          sel, waited;
    rst = 1; s_tvalid = 0; s_tdata = '0; s_tuser = 1'b0; burst_left = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: zero qty, extremes, rest, cross, full fill, cancel
    add_order(32'h0000_0001, 1'b0, 20'd100, 24'd0);
    send_req(lob_pkg::MODE_CANCEL, 32'h1234_5678, 1'b0, '0, '0);
    add_order(32'hFFFF_FFFF, 1'b1, 20'hFFFFF, 24'hFFFFFF);
    add_order(32'h0000_0000, 1'b0, 20'd0, 24'hFFFFFF);
    add_order(32'h0000_0002, 1'b0, 20'hFFFFF, 24'd5);
    add_order(32'h0000_0003, 1'b1, 20'd500, 24'd10);
    add_order(32'h0000_0004, 1'b1, 20'd500, 24'd7);
    add_order(32'h0000_0005, 1'b0, 20'd600, 24'd12);
    add_order(32'h0000_0006, 1'b1, 20'd0, 24'hFFFFFF);
    send_req(lob_pkg::MODE_CANCEL, 32'hFFFF_FFFF, 1'b1, 20'hFFFFF, 24'hFFFFFF);
    send_req(lob_pkg::MODE_CANCEL, 32'h0000_0006, 1'b0, '0, '0);
    // duplicate id in both books, one cancel removes all
    add_order(32'h0000_0077, 1'b0, 20'd10, 24'd3);
    add_order(32'h0000_0077, 1'b1, 20'd900, 24'd3);
    send_req(lob_pkg::MODE_CANCEL, 32'h0000_0077, 1'b0, '0, '0);
    // fill the bid book to reject, then sweep it with one large sell
    for (int i = 0; i < Depth + 1; i++)
      add_order(32'h1000 + 32'(i), 1'b0, 20'(200 + i % 4), 24'(1 + i));
    add_order(32'h2000, 1'b0, 20'd150, 24'd9);
    add_order(32'h2001, 1'b1, 20'd1, 24'hFFFFFF);
    send_req(lob_pkg::MODE_CANCEL, 32'h2001, 1'b0, '0, '0);
    send_req(lob_pkg::MODE_CANCEL, 32'h0000_0000, 1'b0, '0, '0);

    // random traffic around a narrow band so orders cross often
    next_id = 32'h0001_0000;
    for (int n = 0; n < 270; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        cid = (used_ids.size() > 0 && $urandom_range(0, 3) != 0)
            ? used_ids[$urandom_range(0, used_ids.size() - 1)] : $urandom;
        send_req(lob_pkg::MODE_CANCEL, cid, 1'($urandom_range(0, 1)),
                 20'($urandom), 24'($urandom));
      end else begin
        px = (sel < 95) ? 20'(1000 + $urandom_range(0, 20)) : 20'($urandom);
        q  = (sel < 90) ? 24'($urandom_range(1, 200)) : 24'($urandom);
        if (sel == 50) q = '0;
        next_id += $urandom_range(1, 3);
        add_order(($urandom_range(0, 15) == 0) ? $urandom : next_id,
                  1'($urandom_range(0, 1)), px, q);
      end
    end
    s_tvalid = 0;

    // drain, then a short settle
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    $display("covered %0d trade beats and %0d status beats over adds and cancels",
             n_trades, n_status);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
